@@ src/lpsc_pkg.sv @@
package lpsc_pkg;

  localparam int STORE_DEPTH = 4096;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int CNT_W       = $clog2(STORE_DEPTH + 1);

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  localparam logic [1:0] MARK_COPY = 2'd0;
  localparam logic [1:0] MARK_ZERO = 2'd1;
  localparam logic [1:0] MARK_ONE  = 2'd2;

  localparam int ENTRY_W = 10;

  typedef struct packed {
    logic [7:0] data;
    logic [1:0] mark;
    logic       end_of_packet;
    logic       converted;
    logic       overflowed;
  } queue_entry_t;

  typedef struct packed {
    logic         valid;
    queue_entry_t entry;
  } queue_push_t;

  typedef struct packed {
    logic [QCNT_W-1:0] count;
    logic              empty;
  } queue_status_t;

endpackage

@@ src/lpsc_in_if.sv @@
interface lpsc_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output command, output data_byte, output last_byte,
                  input ready);
  modport sink (input valid, input command, input data_byte, input last_byte,
                output ready);
endinterface

@@ src/lpsc_out_if.sv @@
interface lpsc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       end_of_packet;
  logic       converted;
  logic       overflowed;

  modport source (output valid, output out_byte, output end_of_packet, output converted,
                  output overflowed, input ready);
  modport sink (input valid, input out_byte, input end_of_packet, input converted,
                input overflowed, output ready);
endinterface

@@ src/lpsc_ram.sv @@
module lpsc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ src/lpsc_front.sv @@
module lpsc_front (
  input  logic                   clk,
  input  logic                   rst,
  lpsc_in_if.sink                in_ch,
  input  lpsc_pkg::queue_status_t qstat,
  output lpsc_pkg::queue_push_t   push
);
  import lpsc_pkg::*;

  logic [CNT_W-1:0]  load_count, load_count_next;
  logic [CNT_W-1:0]  drain_index, drain_index_next;
  logic [1:0]        field_position, field_position_next;
  logic [23:0]       length_accum, length_accum_next;
  logic [31:0]       payload_left, payload_left_next;
  logic              rest_is_payload, rest_is_payload_next;
  logic              packet_ready, packet_ready_next;
  logic              packet_consistent, packet_consistent_next;
  logic              overflow_seen, overflow_seen_next;
  logic              rd_pending, rd_pending_next;
  logic              rd_eop, rd_conv, rd_ovf;

  // Values as seen by a load: a completed packet is dropped first.
  logic [CNT_W-1:0]  cur_count;
  logic [1:0]        cur_fp;
  logic [23:0]       cur_acc;
  logic [31:0]       cur_left;
  logic              cur_rest;
  logic              cur_consistent;
  logic              cur_ovf;

  logic              accept, drain_hit;
  logic              wr_en, rd_en;
  logic [1:0]        mark;
  logic [ENTRY_W-1:0] rd_data;
  logic [QCNT_W:0]   used;

  assign used         = {1'b0, qstat.count} + {{QCNT_W{1'b0}}, rd_pending};
  assign in_ch.ready  = used < (QCNT_W + 1)'(QUEUE_DEPTH);
  assign accept       = in_ch.valid && in_ch.ready;
  assign drain_hit    = packet_ready && (drain_index < load_count);

  always_comb begin
    cur_count      = packet_ready ? '0 : load_count;
    cur_fp         = packet_ready ? 2'd0 : field_position;
    cur_acc        = packet_ready ? '0 : length_accum;
    cur_left       = packet_ready ? '0 : payload_left;
    cur_rest       = packet_ready ? 1'b0 : rest_is_payload;
    cur_consistent = packet_ready ? 1'b1 : packet_consistent;
    cur_ovf        = packet_ready ? 1'b0 : overflow_seen;

    load_count_next        = load_count;
    drain_index_next       = drain_index;
    field_position_next    = field_position;
    length_accum_next      = length_accum;
    payload_left_next      = payload_left;
    rest_is_payload_next   = rest_is_payload;
    packet_ready_next      = packet_ready;
    packet_consistent_next = packet_consistent;
    overflow_seen_next     = overflow_seen;
    rd_pending_next        = 1'b0;
    wr_en                  = 1'b0;
    rd_en                  = 1'b0;
    mark                   = MARK_COPY;

    if (accept && in_ch.command == CMD_LOAD) begin
      load_count_next        = cur_count;
      drain_index_next       = '0;
      field_position_next    = cur_fp;
      length_accum_next      = cur_acc;
      payload_left_next      = cur_left;
      rest_is_payload_next   = cur_rest;
      packet_ready_next      = 1'b0;
      packet_consistent_next = cur_consistent;
      overflow_seen_next     = cur_ovf;

      if (cur_count >= CNT_W'(STORE_DEPTH)) begin
        overflow_seen_next = 1'b1;
      end else begin
        wr_en = 1'b1;
        if (cur_left != 32'd0) begin
          payload_left_next = cur_left - 32'd1;
        end else begin
          if (!cur_rest) begin
            mark = (cur_fp == 2'd3) ? MARK_ONE : MARK_ZERO;
          end
          if (cur_fp == 2'd3) begin
            payload_left_next = {cur_acc, in_ch.data_byte};
            if (cur_acc == 24'd0 && in_ch.data_byte == 8'd1) begin
              rest_is_payload_next = 1'b1;
            end
            length_accum_next   = '0;
            field_position_next = 2'd0;
          end else begin
            length_accum_next   = {cur_acc[15:0], in_ch.data_byte};
            field_position_next = cur_fp + 2'd1;
          end
        end
        load_count_next = cur_count + CNT_W'(1);
      end

      if (in_ch.last_byte) begin
        if (field_position_next != 2'd0 || payload_left_next != 32'd0) begin
          packet_consistent_next = 1'b0;
        end
        packet_ready_next = 1'b1;
      end
    end else if (accept && in_ch.command == CMD_DRAIN && drain_hit) begin
      rd_en            = 1'b1;
      drain_index_next = drain_index + CNT_W'(1);
      rd_pending_next  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      load_count        <= '0;
      drain_index       <= '0;
      field_position    <= 2'd0;
      length_accum      <= '0;
      payload_left      <= '0;
      rest_is_payload   <= 1'b0;
      packet_ready      <= 1'b0;
      packet_consistent <= 1'b1;
      overflow_seen     <= 1'b0;
      rd_pending        <= 1'b0;
    end else begin
      load_count        <= load_count_next;
      drain_index       <= drain_index_next;
      field_position    <= field_position_next;
      length_accum      <= length_accum_next;
      payload_left      <= payload_left_next;
      rest_is_payload   <= rest_is_payload_next;
      packet_ready      <= packet_ready_next;
      packet_consistent <= packet_consistent_next;
      overflow_seen     <= overflow_seen_next;
      rd_pending        <= rd_pending_next;
    end
  end

  // Flags that travel alongside the byte being read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_eop  <= (drain_index + CNT_W'(1)) == load_count;
      rd_conv <= packet_consistent && !overflow_seen;
      rd_ovf  <= overflow_seen;
    end
  end

  lpsc_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (cur_count[ADDR_W-1:0]),
    .wr_data ({in_ch.data_byte, mark}),
    .rd_en   (rd_en),
    .rd_addr (drain_index[ADDR_W-1:0]),
    .rd_data (rd_data)
  );

  assign push.valid               = rd_pending;
  assign push.entry.data          = rd_data[ENTRY_W-1:2];
  assign push.entry.mark          = rd_data[1:0];
  assign push.entry.end_of_packet = rd_eop;
  assign push.entry.converted     = rd_conv;
  assign push.entry.overflowed    = rd_ovf;

endmodule

@@ src/lpsc_queue.sv @@
module lpsc_queue (
  input  logic                    clk,
  input  logic                    rst,
  input  lpsc_pkg::queue_push_t   push,
  input  logic                    pop,
  output lpsc_pkg::queue_entry_t  head,
  output lpsc_pkg::queue_status_t qstat
);
  import lpsc_pkg::*;

  queue_entry_t      slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count, count_next;

  always_comb begin
    count_next = count;
    if (push.valid && !pop) begin
      count_next = count + QCNT_W'(1);
    end else if (!push.valid && pop) begin
      count_next = count - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push.valid) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      slots[wr_ptr] <= push.entry;
    end
  end

  assign head        = slots[rd_ptr];
  assign qstat.count = count;
  assign qstat.empty = (count == '0);

endmodule

@@ src/lpsc_back.sv @@
module lpsc_back (
  input  logic                    clk,
  input  logic                    rst,
  input  lpsc_pkg::queue_entry_t  head,
  input  lpsc_pkg::queue_status_t qstat,
  output logic                    pop,
  lpsc_out_if.source              out_ch
);
  import lpsc_pkg::*;

  logic [7:0] byte_value;

  // Length bytes are replaced only when the packet converts.
  always_comb begin
    byte_value = head.data;
    if (head.converted) begin
      case (head.mark)
        MARK_ZERO: byte_value = 8'h00;
        MARK_ONE:  byte_value = 8'h01;
        default:   byte_value = head.data;
      endcase
    end
  end

  assign pop = !qstat.empty && (!out_ch.valid || out_ch.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (!out_ch.valid || out_ch.ready) begin
      out_ch.valid <= !qstat.empty;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_ch.out_byte      <= byte_value;
      out_ch.end_of_packet <= head.end_of_packet;
      out_ch.converted     <= head.converted;
      out_ch.overflowed    <= head.overflowed;
    end
  end

endmodule

@@ src/length_prefix_to_start_code_core.sv @@
// Length-prefixed NAL packet to start-code converter.
// in_ch carries requests: command 0 loads data_byte into the packet store,
// with last_byte marking the end of the packet; command 1 drains one byte.
// out_ch carries one result for each drain while a complete packet still has
// bytes left; other requests give no result. A load after a complete packet
// starts a new one. A consistent, untruncated packet reads out with every
// length field, up to the first that holds 1, as 00 00 00 01; otherwise it
// reads out as stored. One request is accepted per cycle while in_ch.ready
// is high. A drain reads the store into its read register, its result is
// written into a four-entry queue and from there passes to the output
// register. The front stops accepting only when the queue and the read
// in flight would fill the queue, so the store port and the output register
// each sustain one byte per cycle while out_ch.ready stays high.
// Reset clears all control state; the store holds no valid bits and only
// entries written by the current packet are read.
// When the receiver stalls, the output register holds its byte, the queue
// fills, and in_ch.ready falls until room frees up again.
module length_prefix_to_start_code_core (
  input logic        clk,
  input logic        rst,
  lpsc_in_if.sink    in_ch,
  lpsc_out_if.source out_ch
);
  import lpsc_pkg::*;

  queue_push_t   push;
  queue_entry_t  head;
  queue_status_t qstat;
  logic          pop;

  lpsc_front u_front (
    .clk   (clk),
    .rst   (rst),
    .in_ch (in_ch),
    .qstat (qstat),
    .push  (push)
  );

  lpsc_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .pop   (pop),
    .head  (head),
    .qstat (qstat)
  );

  lpsc_back u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .qstat  (qstat),
    .pop    (pop),
    .out_ch (out_ch)
  );

  a_no_overfill: assert property (@(posedge clk) disable iff (rst)
    (push.valid && !pop) |-> (qstat.count < QCNT_W'(QUEUE_DEPTH)))
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !qstat.empty)
    else $error("queue read while empty");

  a_conv_clean: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.converted) |-> !out_ch.overflowed)
    else $error("converted result from a truncated packet");

endmodule
